// File: rtl/core/trm_pkg.sv
package trm_pkg;

  localparam int NumRegs  = 8;
  localparam int IdxReg   = NumRegs - 1;
  localparam int FlgReg   = NumRegs - 2;
  // General registers below the flag register live in the memory.
  localparam int MemDepth = NumRegs - 2;
  localparam int MemAw    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  // Register selects are compared one bit wider than the 3-bit fields.
  localparam int SelW = 4;
  localparam logic [SelW-1:0] IdxSel = SelW'(IdxReg);
  localparam logic [SelW-1:0] FlgSel = SelW'(FlgReg);
  localparam logic [SelW-1:0] MemSel = SelW'(MemDepth);
  localparam logic [SelW-1:0] NumSel = SelW'(NumRegs);

  localparam logic [31:0] FlagEqualTo     = 32'd1;
  localparam logic [31:0] FlagGreaterThan = 32'd2;
  localparam logic [31:0] FlagLessThan    = 32'd3;

  typedef enum logic [2:0] {
    OpMov = 3'd0,
    OpAdd = 3'd1,
    OpSub = 3'd2,
    OpCmp = 3'd3,
    OpJeq = 3'd4,
    OpJgt = 3'd5,
    OpJlt = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [2:0]         dest_reg;
    logic               a_is_reg;
    logic [2:0]         a_reg;
    logic signed [31:0] a_const;
    logic               b_is_reg;
    logic [2:0]         b_reg;
    logic signed [31:0] b_const;
    logic [15:0]        jump_target;
  } trm_in_t;

  typedef struct packed {
    logic signed [31:0] next_index;
    logic signed [31:0] flag_value;
    logic signed [31:0] written_value;
    logic               wrote_reg;
  } trm_out_t;

  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] a_addr;
    logic [MemAw-1:0] b_addr;
  } rf_rd_t;

  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] addr;
    logic [31:0]      data;
  } rf_wr_t;

endpackage

// File: rtl/core/trm_regfile.sv
module trm_regfile import trm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rf_rd_t      rd_i,
  input  rf_wr_t      wr_i,
  output logic [31:0] rd_a_data_o,
  output logic [31:0] rd_b_data_o
);

  logic [31:0]         mem [MemDepth];
  logic [MemDepth-1:0] vld_q;
  logic [31:0]         rdata_a_q, rdata_b_q;
  logic [MemAw-1:0]    addr_a_q, addr_b_q;
  logic                vld_a_q, vld_b_q;
  logic                fwd_en_q;
  logic [MemAw-1:0]    fwd_addr_q;
  logic [31:0]         fwd_data_q;
  logic                hit_a, hit_b;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    // A write at the same edge as the read is captured for bypass, since
    // the array returns the old contents.
    if (rd_i.en) begin
      rdata_a_q  <= mem[rd_i.a_addr];
      rdata_b_q  <= mem[rd_i.b_addr];
      addr_a_q   <= rd_i.a_addr;
      addr_b_q   <= rd_i.b_addr;
      fwd_addr_q <= wr_i.addr;
      fwd_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_a_q  <= 1'b0;
      vld_b_q  <= 1'b0;
      fwd_en_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        vld_a_q  <= vld_q[rd_i.a_addr];
        vld_b_q  <= vld_q[rd_i.b_addr];
        fwd_en_q <= wr_i.en;
      end
    end
  end

  assign hit_a = fwd_en_q && (fwd_addr_q == addr_a_q);
  assign hit_b = fwd_en_q && (fwd_addr_q == addr_b_q);

  // An entry never written since reset reads as zero.
  assign rd_a_data_o = hit_a ? fwd_data_q : (vld_a_q ? rdata_a_q : '0);
  assign rd_b_data_o = hit_b ? fwd_data_q : (vld_b_q ? rdata_b_q : '0);

endmodule

// File: rtl/core/tiny_register_machine_step.sv
// A request accepted at a clock edge is registered in the execute stage; its result moves into the output
// register once that register is free, and is held on the output until it is taken.
// Throughput: one request per cycle unless the output stalls; the register file memory is read
// at acceptance and written back when the execute stage moves its result into the output register.
// Reset: asynchronous, active low; all registers read as zero and both stages come up empty.
// Input stall rises only while the execute stage is full and its result cannot move on.
module tiny_register_machine_step import trm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  trm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output trm_out_t out_data_o
);

  logic        in_accept;
  logic        out_free;
  logic        e_fire;
  logic        e_valid_q;
  trm_in_t     e_q;
  logic [31:0] idx_q, idx_d;
  logic [31:0] flag_q, flag_d;
  logic        out_valid_q;
  trm_out_t    out_q;
  rf_rd_t      rf_rd;
  rf_wr_t      rf_wr;
  logic [31:0] rf_a_data, rf_b_data;
  logic [31:0] idx_inc, opa, opb, val;
  logic        wr;
  logic [SelW-1:0] a_sel, b_sel, d_sel, in_a_sel, in_b_sel;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign e_fire     = e_valid_q && out_free;
  assign in_stall_o = e_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_a_sel = {1'b0, in_data_i.a_reg};
  assign in_b_sel = {1'b0, in_data_i.b_reg};

  always_comb begin
    rf_rd.en     = in_accept;
    rf_rd.a_addr = (in_a_sel < MemSel) ? in_data_i.a_reg[MemAw-1:0] : '0;
    rf_rd.b_addr = (in_b_sel < MemSel) ? in_data_i.b_reg[MemAw-1:0] : '0;
  end

  trm_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (rf_rd),
    .wr_i        (rf_wr),
    .rd_a_data_o (rf_a_data),
    .rd_b_data_o (rf_b_data)
  );

  assign a_sel   = {1'b0, e_q.a_reg};
  assign b_sel   = {1'b0, e_q.b_reg};
  assign d_sel   = {1'b0, e_q.dest_reg};
  assign idx_inc = idx_q + 32'd1;

  // Register operands see the index after its increment.
  always_comb begin
    if (!e_q.a_is_reg) begin
      opa = e_q.a_const;
    end else if (a_sel == IdxSel) begin
      opa = idx_inc;
    end else if (a_sel == FlgSel) begin
      opa = flag_q;
    end else if (a_sel < MemSel) begin
      opa = rf_a_data;
    end else begin
      opa = '0;
    end
    if (!e_q.b_is_reg) begin
      opb = e_q.b_const;
    end else if (b_sel == IdxSel) begin
      opb = idx_inc;
    end else if (b_sel == FlgSel) begin
      opb = flag_q;
    end else if (b_sel < MemSel) begin
      opb = rf_b_data;
    end else begin
      opb = '0;
    end
  end

  always_comb begin
    val    = '0;
    wr     = 1'b0;
    idx_d  = idx_inc;
    flag_d = flag_q;
    case (e_q.mode)
      OpMov: begin
        val = opa;
        wr  = 1'b1;
      end
      OpAdd: begin
        val = opa + opb;
        wr  = 1'b1;
      end
      OpSub: begin
        val = opa - opb;
        wr  = 1'b1;
      end
      OpCmp: begin
        if (opa == opb) begin
          flag_d = FlagEqualTo;
        end else if ($signed(opa) > $signed(opb)) begin
          flag_d = FlagGreaterThan;
        end else begin
          flag_d = FlagLessThan;
        end
      end
      OpJeq: begin
        if (flag_q == FlagEqualTo) idx_d = {16'b0, e_q.jump_target};
      end
      OpJgt: begin
        if (flag_q == FlagGreaterThan) idx_d = {16'b0, e_q.jump_target};
      end
      OpJlt: begin
        if (flag_q == FlagLessThan) idx_d = {16'b0, e_q.jump_target};
      end
      default: begin
      end
    endcase

    rf_wr.en   = 1'b0;
    rf_wr.addr = e_q.dest_reg[MemAw-1:0];
    rf_wr.data = val;
    if (wr && (d_sel < NumSel)) begin
      if (d_sel == IdxSel) begin
        idx_d = val;
      end else if (d_sel == FlgSel) begin
        flag_d = val;
      end else begin
        rf_wr.en = e_fire;
      end
    end else begin
      wr  = 1'b0;
      val = '0;
      rf_wr.data = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      flag_q      <= '0;
    end else begin
      if (in_accept) begin
        e_valid_q <= 1'b1;
      end else if (e_fire) begin
        e_valid_q <= 1'b0;
      end
      if (e_fire) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_d;
        flag_q      <= flag_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      e_q <= in_data_i;
    end
    if (e_fire) begin
      out_q.next_index    <= idx_d;
      out_q.flag_value    <= flag_d;
      out_q.written_value <= val;
      out_q.wrote_reg     <= wr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/trm_step_checker.sv
module trm_step_checker import trm_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input trm_out_t out_data_o
);

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // The input side is held back only when the output is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A step that writes nothing reports a zero value.
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.wrote_reg |-> out_data_o.written_value == 32'sd0)
    else $error("nonzero value without a register write");

  // A new result rises only when the input side was not stalled just before it.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o) == 1'b0)
    else $error("result appeared while input side was stalled");

endmodule

bind tiny_register_machine_step trm_step_checker u_trm_step_checker (.*);
